/* design/i2cmrs_pkg.sv */
// Shared types, codes and constants for the I2C master read sequencer.
package i2cmrs_pkg;

    localparam int QDEPTH = 2;

    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_ACK   = 3'd1;
    localparam logic [2:0] KIND_NACK  = 3'd2;
    localparam logic [2:0] KIND_RX    = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    typedef enum logic [2:0] {
        EV_START,
        EV_ACK,
        EV_NACK,
        EV_RX,
        EV_STOP,
        EV_BAD
    } ev_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_REQ_DEV,
        PH_WRITE,
        PH_REQ_DATA,
        PH_READ,
        PH_CLOSE
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_ADDR_W     = 3'd1,
        ACT_CMD        = 3'd2,
        ACT_ADDR_R     = 3'd3,
        ACT_STORE_ACK  = 3'd4,
        ACT_STORE_STOP = 3'd5,
        ACT_DONE       = 3'd6,
        ACT_ERROR      = 3'd7
    } action_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  dev_addr;
        logic        read_request;
        logic [7:0]  cmd_byte;
        logic [7:0]  read_length;
        logic [31:0] completion_tag;
        logic [7:0]  rx_byte;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx_byte;
        logic [7:0]  store_index;
        logic [7:0]  store_byte;
        logic [31:0] done_tag;
        logic        busy_res;
    } rsp_item_t;

    typedef struct packed {
        ev_t       ev;
        req_item_t data;
    } q_item_t;

endpackage

/* design/i2cmrs_front.sv */
// Front end: takes request items and decodes the event kind for the queue.
module i2cmrs_front (
    input  logic                 req_valid,
    output logic                 req_stall,
    input  i2cmrs_pkg::req_item_t req,
    input  logic                 q_full,
    output logic                 push,
    output i2cmrs_pkg::q_item_t  entry
);
    import i2cmrs_pkg::*;

    ev_t ev;

    always_comb
    begin
        case (req.kind)
            KIND_START: ev = EV_START;
            KIND_ACK:   ev = EV_ACK;
            KIND_NACK:  ev = EV_NACK;
            KIND_RX:    ev = EV_RX;
            KIND_STOP:  ev = EV_STOP;
            default:    ev = EV_BAD;
        endcase
    end

    assign req_stall  = q_full;
    assign push       = req_valid && !q_full;
    assign entry.ev   = ev;
    assign entry.data = req;

endmodule

/* design/i2cmrs_queue.sv */
// Short item queue between the front end and the sequencer.
module i2cmrs_queue #(
    parameter int DEPTH = i2cmrs_pkg::QDEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  i2cmrs_pkg::q_item_t wr_item,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output i2cmrs_pkg::q_item_t rd_item
);
    import i2cmrs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_item_t        store_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_item = store_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* design/i2cmrs_back.sv */
// Back end: transaction phase machine and registered result item.
module i2cmrs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  i2cmrs_pkg::q_item_t   head,
    output logic                  pop,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output i2cmrs_pkg::rsp_item_t rsp
);
    import i2cmrs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [6:0]  addr_reg, addr_next;
    logic        reading_reg, reading_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  limit_reg, limit_next;
    logic [7:0]  saved_reg, saved_next;
    logic [31:0] tag_reg, tag_next;
    logic        out_valid_reg, out_valid_next;
    rsp_item_t   out_reg;
    rsp_item_t   res;
    logic [7:0]  saved_inc;
    logic        last_byte;

    assign pop       = q_valid && (!out_valid_reg || !rsp_stall);
    assign saved_inc = saved_reg + 8'd1;
    assign last_byte = (saved_inc >= limit_reg) || (saved_inc == 8'd0);

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        reading_next = reading_reg;
        cmd_next     = cmd_reg;
        limit_next   = limit_reg;
        saved_next   = saved_reg;
        tag_next     = tag_reg;
        if (pop)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (head.ev == EV_START)
                    begin
                        addr_next    = head.data.dev_addr;
                        reading_next = head.data.read_request;
                        cmd_next     = head.data.cmd_byte;
                        limit_next   = head.data.read_length;
                        tag_next     = head.data.completion_tag;
                        saved_next   = 8'd0;
                        phase_next   = PH_REQ_DEV;
                    end
                end
                PH_REQ_DEV:
                begin
                    if (head.ev == EV_ACK)
                    begin
                        phase_next = PH_WRITE;
                    end
                end
                PH_WRITE:
                begin
                    if (head.ev == EV_ACK && reading_reg)
                    begin
                        phase_next = PH_REQ_DATA;
                    end
                end
                PH_REQ_DATA:
                begin
                    if (head.ev == EV_ACK)
                    begin
                        phase_next = PH_READ;
                    end
                end
                PH_READ:
                begin
                    if (head.ev == EV_RX)
                    begin
                        saved_next = saved_inc;
                        if (last_byte)
                        begin
                            phase_next = PH_CLOSE;
                        end
                    end
                end
                PH_CLOSE:
                begin
                    if (head.ev == EV_STOP)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result for the head item
    always_comb
    begin
        res             = '0;
        res.action      = ACT_ERROR;
        res.busy_res    = (phase_next != PH_IDLE);
        case (phase_reg)
            PH_IDLE:
            begin
                if (head.ev == EV_START)
                begin
                    res.action  = ACT_ADDR_W;
                    res.tx_byte = {head.data.dev_addr, 1'b0};
                end
            end
            PH_REQ_DEV:
            begin
                if (head.ev == EV_ACK)
                begin
                    res.action  = ACT_CMD;
                    res.tx_byte = cmd_reg;
                end
            end
            PH_WRITE:
            begin
                if (head.ev == EV_ACK)
                begin
                    if (reading_reg)
                    begin
                        res.action  = ACT_ADDR_R;
                        res.tx_byte = {addr_reg, 1'b1};
                    end
                    else
                    begin
                        res.action = ACT_NONE;
                    end
                end
            end
            PH_REQ_DATA:
            begin
                if (head.ev == EV_ACK)
                begin
                    res.action = ACT_NONE;
                end
                else if (head.ev == EV_NACK)
                begin
                    if (reading_reg)
                    begin
                        res.action  = ACT_ADDR_R;
                        res.tx_byte = {addr_reg, 1'b1};
                    end
                    else
                    begin
                        res.action = ACT_NONE;
                    end
                end
            end
            PH_READ:
            begin
                if (head.ev == EV_RX)
                begin
                    res.action      = last_byte ? ACT_STORE_STOP : ACT_STORE_ACK;
                    res.store_index = saved_reg;
                    res.store_byte  = head.data.rx_byte;
                end
            end
            PH_CLOSE:
            begin
                if (head.ev == EV_STOP)
                begin
                    res.action   = ACT_DONE;
                    res.done_tag = tag_reg;
                end
            end
            default:
            begin
                res.action = ACT_ERROR;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            addr_reg      <= '0;
            reading_reg   <= 1'b0;
            cmd_reg       <= '0;
            limit_reg     <= '0;
            saved_reg     <= '0;
            tag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            addr_reg      <= addr_next;
            reading_reg   <= reading_next;
            cmd_reg       <= cmd_next;
            limit_reg     <= limit_next;
            saved_reg     <= saved_next;
            tag_reg       <= tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

/* design/i2c_master_read_sequencer.sv */
// Top level of the I2C master read sequencer.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | i2cmrs_pkg::req_item_t
//  rsp     | out       | rsp_valid / rsp_stall | i2cmrs_pkg::rsp_item_t
//
// One item per cycle sustained while rsp_stall stays low; each item gives one result item.
// An accepted item is registered in the queue, then in the result register that drives rsp_valid.
// The phase machine advances at most once per item, set by the single back-end update.
// rst_n clears the phase, latched request fields, queue and result valid.
// req_stall rises when the queue is full; rsp_stall holds the result register.
module i2c_master_read_sequencer #(
    parameter int QUEUE_DEPTH = i2cmrs_pkg::QDEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  i2cmrs_pkg::req_item_t req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output i2cmrs_pkg::rsp_item_t rsp
);
    import i2cmrs_pkg::*;

    logic    push;
    logic    q_full;
    logic    q_valid;
    logic    pop;
    q_item_t entry;
    q_item_t head;

    i2cmrs_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .entry     (entry)
    );

    i2cmrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (entry),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .rd_item (head)
    );

    i2cmrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* design/i2cmrs_checker.sv */
// Port-level checks for the I2C master read sequencer, bound to the top level.
module i2cmrs_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rsp_valid,
    input logic                  rsp_stall,
    input i2cmrs_pkg::rsp_item_t rsp
);
    import i2cmrs_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.action == ACT_DONE |-> !rsp.busy_res)
        else $error("done item reported busy");

    a_addr_w: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.action == ACT_ADDR_W |-> rsp.busy_res && !rsp.tx_byte[0])
        else $error("address write item malformed");

    a_addr_r: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.action == ACT_ADDR_R |-> rsp.busy_res && rsp.tx_byte[0])
        else $error("address read item malformed");

    a_store_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.action != ACT_STORE_ACK && rsp.action != ACT_STORE_STOP
        |-> rsp.store_byte == 8'd0 && rsp.store_index == 8'd0)
        else $error("store fields set on non-store item");

endmodule

bind i2c_master_read_sequencer i2cmrs_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* dv/i2c_master_read_sequencer_test.sv */
// Testbench for the I2C master read sequencer: directed and random event streams checked per item.
module i2c_master_read_sequencer_test;
    import i2cmrs_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    phase_t      seq_phase;
    logic [6:0]  seq_addr;
    logic        seq_reading;
    logic [7:0]  seq_cmd;
    logic [7:0]  seq_len;
    logic [7:0]  seq_count;
    logic [31:0] seq_tag;

    rsp_item_t expected_actions[$];
    rsp_item_t want;
    int        errors = 0;
    int        sent_items = 0;
    int        results_seen = 0;
    int        hold_cycles = 0;
    int        stall_run = 0;
    bit        quiet = 1'b0;

    i2c_master_read_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Phase machine: one action per bus event
    function automatic rsp_item_t advance_sequencer(req_item_t it);
        rsp_item_t r;
        r = '0;
        r.action = ACT_ERROR;
        case (it.kind)
            KIND_START:
                if (seq_phase == PH_IDLE)
                begin
                    seq_addr    = it.dev_addr;
                    seq_reading = it.read_request;
                    seq_cmd     = it.cmd_byte;
                    seq_len     = it.read_length;
                    seq_tag     = it.completion_tag;
                    seq_count   = '0;
                    seq_phase   = PH_REQ_DEV;
                    r.action    = ACT_ADDR_W;
                    r.tx_byte   = {seq_addr, 1'b0};
                end
            KIND_ACK:
                if (seq_phase == PH_REQ_DEV)
                begin
                    seq_phase = PH_WRITE;
                    r.action  = ACT_CMD;
                    r.tx_byte = seq_cmd;
                end
                else if (seq_phase == PH_WRITE)
                begin
                    if (seq_reading)
                    begin
                        seq_phase = PH_REQ_DATA;
                        r.action  = ACT_ADDR_R;
                        r.tx_byte = {seq_addr, 1'b1};
                    end
                    else
                        r.action = ACT_NONE;
                end
                else if (seq_phase == PH_REQ_DATA)
                begin
                    seq_phase = PH_READ;
                    r.action  = ACT_NONE;
                end
            KIND_NACK:
                if (seq_phase == PH_REQ_DATA)
                begin
                    if (seq_reading)
                    begin
                        r.action  = ACT_ADDR_R;
                        r.tx_byte = {seq_addr, 1'b1};
                    end
                    else
                        r.action = ACT_NONE;
                end
            KIND_RX:
                if (seq_phase == PH_READ)
                begin
                    r.store_index = seq_count;
                    r.store_byte  = it.rx_byte;
                    seq_count     = seq_count + 8'd1;
                    if (seq_count >= seq_len || seq_count == 8'd0)
                    begin
                        seq_phase = PH_CLOSE;
                        r.action  = ACT_STORE_STOP;
                    end
                    else
                        r.action = ACT_STORE_ACK;
                end
            KIND_STOP:
                if (seq_phase == PH_CLOSE)
                begin
                    seq_phase  = PH_IDLE;
                    r.action   = ACT_DONE;
                    r.done_tag = seq_tag;
                end
            default:
                ;
        endcase
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    function automatic req_item_t make_item(logic [2:0] kind);
        req_item_t it;
        it.kind           = kind;
        it.dev_addr       = 7'($urandom);
        it.read_request   = 1'($urandom);
        it.cmd_byte       = 8'($urandom);
        it.read_length    = 8'($urandom);
        it.completion_tag = $urandom;
        it.rx_byte        = 8'($urandom);
        return it;
    endfunction

    // Any kind, any fields; a start from idle always reads so the machine can finish
    function automatic req_item_t noise_item();
        req_item_t it;
        it = make_item(3'($urandom_range(0, 7)));
        if (it.kind == KIND_START && seq_phase == PH_IDLE)
            it.read_request = 1'b1;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        errors++;
        if (errors <= 40)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, exp_val);
    endtask

    task automatic send_item(input req_item_t it);
        int gap;
        gap = quiet ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
        expected_actions.push_back(advance_sequencer(it));
        sent_items++;
    endtask

    task automatic send_kind(input logic [2:0] kind);
        send_item(make_item(kind));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge clk);
    endtask

    // Walk an open transaction home with events it expects
    task automatic recover_to_idle();
        while (seq_phase != PH_IDLE)
        begin
            case (seq_phase)
                PH_READ:  send_kind(KIND_RX);
                PH_CLOSE: send_kind(KIND_STOP);
                default:  send_kind(KIND_ACK);
            endcase
        end
    endtask

    task automatic run_read(input logic [7:0] len, input bit noisy);
        req_item_t  it;
        logic [2:0] steps[$];
        int         nacks;
        int         n_rx;
        int         keep;
        recover_to_idle();
        it = make_item(KIND_START);
        it.read_request = 1'b1;
        it.read_length  = len;
        send_item(it);
        nacks = $urandom_range(0, 2);
        n_rx  = (len == 8'd0) ? 1 : int'(len);
        steps.push_back(KIND_ACK);
        steps.push_back(KIND_ACK);
        repeat (nacks) steps.push_back(KIND_NACK);
        steps.push_back(KIND_ACK);
        repeat (n_rx) steps.push_back(KIND_RX);
        steps.push_back(KIND_STOP);
        keep = steps.size();
        if (noisy && $urandom_range(0, 9) == 0)
            keep = $urandom_range(0, steps.size() - 1);
        for (int i = 0; i < keep; i++)
        begin
            if (noisy && $urandom_range(0, 99) < 8)
                send_item(noise_item());
            send_kind(steps[i]);
        end
    endtask

    task automatic test_idle_events();
        send_kind(KIND_ACK);
        send_kind(KIND_NACK);
        send_kind(KIND_RX);
        send_kind(KIND_STOP);
        for (int k = KIND_STOP + 1; k < 8; k++)
            send_kind(3'(k));
    endtask

    task automatic test_read_extremes();
        req_item_t it;
        it = make_item(KIND_START);
        it.dev_addr       = 7'h7F;
        it.read_request   = 1'b1;
        it.cmd_byte       = 8'hFF;
        it.read_length    = 8'd0;
        it.completion_tag = 32'hFFFF_FFFF;
        send_item(it);
        it = make_item(KIND_START);
        it.read_request = 1'b0;
        send_item(it);
        send_kind(KIND_ACK);
        send_kind(KIND_NACK);
        send_kind(KIND_ACK);
        send_kind(KIND_NACK);
        send_kind(KIND_ACK);
        it = make_item(KIND_RX);
        it.rx_byte = 8'hFF;
        send_item(it);
        send_kind(KIND_RX);
        send_kind(KIND_STOP);

        it = make_item(KIND_START);
        it.dev_addr       = 7'h00;
        it.read_request   = 1'b1;
        it.cmd_byte       = 8'h00;
        it.read_length    = 8'd2;
        it.completion_tag = 32'h0;
        send_item(it);
        send_kind(KIND_ACK);
        send_kind(KIND_ACK);
        send_kind(KIND_ACK);
        it = make_item(KIND_RX);
        it.rx_byte = 8'h00;
        send_item(it);
        send_kind(KIND_RX);
        send_kind(KIND_STOP);
    endtask

    // Receiver holds off while items keep coming, so the input side must stall
    task automatic test_back_pressure();
        wait_drain();
        quiet = 1'b1;
        hold_cycles = 60;
        run_read(8'd16, 1'b0);
        wait_drain();
        quiet = 1'b0;
    endtask

    task automatic test_random_reads();
        int r;
        while (sent_items < 1350)
        begin
            if ($urandom_range(0, 24) == 0)
                quiet = !quiet;
            r = $urandom_range(0, 99);
            if (r < 80)
                run_read(8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                         : $urandom_range(7, 40)), 1'b1);
            else if (r < 96)
                repeat ($urandom_range(1, 4)) send_item(noise_item());
            else
                wait_drain();
        end
        quiet = 1'b0;
    endtask

    task automatic test_max_length();
        run_read(8'd255, 1'b0);
    endtask

    // Write-only request never leaves the write phase, so it runs last
    task automatic test_write_only();
        req_item_t it;
        recover_to_idle();
        it = make_item(KIND_START);
        it.read_request = 1'b0;
        send_item(it);
        send_kind(KIND_ACK);
        send_kind(KIND_ACK);
        send_kind(KIND_ACK);
        send_kind(KIND_NACK);
        send_kind(KIND_RX);
        send_kind(KIND_STOP);
        send_kind(KIND_START);
    endtask

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_run > 0)
            begin
                rsp_stall <= 1'b1;
                stall_run--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 99) < 25)
                    stall_run = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_actions.size() == 0)
                report_mismatch("unexpected result, action", 32'(rsp.action), 0);
            else
            begin
                want = expected_actions.pop_front();
                if (rsp.action !== want.action)
                    report_mismatch("action", 32'(rsp.action), 32'(want.action));
                if (rsp.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 32'(rsp.tx_byte), 32'(want.tx_byte));
                if (rsp.store_index !== want.store_index)
                    report_mismatch("store_index", 32'(rsp.store_index),
                                    32'(want.store_index));
                if (rsp.store_byte !== want.store_byte)
                    report_mismatch("store_byte", 32'(rsp.store_byte),
                                    32'(want.store_byte));
                if (rsp.done_tag !== want.done_tag)
                    report_mismatch("done_tag", rsp.done_tag, want.done_tag);
                if (rsp.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 32'(rsp.busy_res), 32'(want.busy_res));
            end
            results_seen++;
        end
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        seq_phase   = PH_IDLE;
        seq_addr    = '0;
        seq_reading = 1'b0;
        seq_cmd     = '0;
        seq_len     = '0;
        seq_count   = '0;
        seq_tag     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_events();
        test_read_extremes();
        test_back_pressure();
        test_random_reads();
        test_max_length();
        test_write_only();

        @(negedge clk);
        req_valid <= 1'b0;
        wait_drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_actions.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/i2cmrs_pkg.sv
design/i2cmrs_front.sv
design/i2cmrs_queue.sv
design/i2cmrs_back.sv
design/i2c_master_read_sequencer.sv
design/i2cmrs_checker.sv
dv/i2c_master_read_sequencer_test.sv
